// ===== design/hcss_pkg.sv =====
package hcss_pkg;

  localparam logic       REQ_TIMEOUT = 1'b0;
  localparam logic       REQ_SET     = 1'b1;

  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_SEC  = 2'd1;
  localparam logic [1:0] SEL_MIN  = 2'd2;
  localparam logic [1:0] SEL_HOUR = 2'd3;

  localparam logic [7:0] TPS_RESET   = 8'd10;
  localparam logic [6:0] SEC_WRAP    = 7'd60;
  localparam logic [6:0] MIN_WRAP    = 7'd60;
  localparam logic [7:0] HOUR_WRAP   = 8'd100;
  localparam logic [4:0] LED_LIMIT   = 5'd16;
  localparam logic [6:0] LED_FREEZE  = 7'd15;
  localparam logic [7:0] SEG_BLANK   = 8'hFF;

  typedef struct packed {
    logic [6:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] led;
  } time_t;

  typedef struct packed {
    logic [7:0] hour_tens;
    logic [7:0] hour_ones;
    logic [7:0] min_tens;
    logic [7:0] min_ones;
    logic [7:0] sec_tens;
    logic [7:0] sec_ones;
  } seg_t;

  function automatic logic [7:0] digit_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'b11000000;
      4'd1:    c = 8'b11111001;
      4'd2:    c = 8'b10100100;
      4'd3:    c = 8'b10110000;
      4'd4:    c = 8'b10011001;
      4'd5:    c = 8'b10010010;
      4'd6:    c = 8'b10000010;
      4'd7:    c = 8'b11111000;
      4'd8:    c = 8'b10000000;
      4'd9:    c = 8'b10011000;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

  // quotient by 10 via reciprocal, exact for every 7-bit input (0 to 127)
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd103;
    return p[13:10];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] r;
    r = v - 7'(div10(v)) * 7'd10;
    return r[3:0];
  endfunction

endpackage

// ===== design/hcss_seg_encode.sv =====
module hcss_seg_encode
  import hcss_pkg::*;
(
  input  time_t tm,
  output seg_t  seg
);

  always_comb begin
    seg.hour_tens = digit_code(div10(tm.hour));
    seg.hour_ones = digit_code(mod10(tm.hour));
    seg.min_tens  = digit_code(div10({1'b0, tm.minute}));
    seg.min_ones  = digit_code(mod10({1'b0, tm.minute}));
    seg.sec_tens  = digit_code(div10({1'b0, tm.second}));
    seg.sec_ones  = digit_code(mod10({1'b0, tm.second}));
  end

endmodule

// ===== design/hcss_time_core.sv =====
module hcss_time_core
  import hcss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       fire,
  input  logic       req_type,
  input  logic [9:0] switch_value,
  output logic       emit,
  output time_t      time_nxt
);

  logic [7:0] tps_r;
  logic [7:0] prescale_r, prescale_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [6:0] hour_r, hour_nxt;
  logic [4:0] led_r, led_nxt;
  logic       frozen_r, frozen_nxt;

  logic [7:0] pre_inc;
  logic       tick;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [7:0] hour_inc;
  logic [1:0] sel;
  logic [5:0] val;

  assign pre_inc  = prescale_r + 8'd1;
  assign tick     = (pre_inc == tps_r);
  assign emit     = (req_type == REQ_SET) || tick;
  assign sec_inc  = {1'b0, sec_r} + 7'd1;
  assign min_inc  = {1'b0, min_r} + 7'd1;
  assign hour_inc = {1'b0, hour_r} + 8'd1;
  assign sel      = switch_value[9:8];
  assign val      = switch_value[5:0];

  always_comb begin
    prescale_nxt = prescale_r;
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    led_nxt      = led_r;
    frozen_nxt   = frozen_r;
    if (req_type == REQ_SET) begin
      case (sel)
        SEL_SEC:  sec_nxt  = val;
        SEL_MIN:  min_nxt  = val;
        SEL_HOUR: hour_nxt = {1'b0, val};
        default:  ;
      endcase
    end else if (!tick) begin
      prescale_nxt = pre_inc;
    end else begin
      prescale_nxt = 8'd0;
      if ((sec_r < 6'(LED_LIMIT)) && !frozen_r) begin
        led_nxt = sec_inc[4:0];
        if (sec_inc == LED_FREEZE) begin
          frozen_nxt = 1'b1;
        end
      end
      sec_nxt = sec_inc[5:0];
      if (sec_inc >= SEC_WRAP) begin
        sec_nxt = 6'd0;
        min_nxt = min_inc[5:0];
        if (min_inc >= MIN_WRAP) begin
          min_nxt  = 6'd0;
          hour_nxt = (hour_inc >= HOUR_WRAP) ? 7'd0 : hour_inc[6:0];
        end
      end
    end
  end

  assign time_nxt = '{hour: hour_nxt, minute: min_nxt, second: sec_nxt, led: led_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r      <= TPS_RESET;
      prescale_r <= 8'd0;
      sec_r      <= 6'd0;
      min_r      <= 6'd0;
      hour_r     <= 7'd0;
      led_r      <= 5'd0;
      frozen_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (fire) begin
        prescale_r <= prescale_nxt;
        sec_r      <= sec_nxt;
        min_r      <= min_nxt;
        hour_r     <= hour_nxt;
        led_r      <= led_nxt;
        frozen_r   <= frozen_nxt;
      end
    end
  end

  a_tick_clears_prescale: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req_type == REQ_TIMEOUT) && tick |=> prescale_r == 8'd0)
    else $error("prescaler not cleared after a second");

  a_sec_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req_type == REQ_TIMEOUT) && tick |=> sec_r < 6'(SEC_WRAP))
    else $error("seconds out of range after advance");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    frozen_r |=> frozen_r && $stable(led_r))
    else $error("frozen LED value changed");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    8'(hour_r) < HOUR_WRAP)
    else $error("hours out of range");

endmodule

// ===== design/hms_clock_seven_segment_core.sv =====
// Hours:minutes:seconds clock driving six active-low seven-segment digits.
// Input channel (in_valid/in_ready): one beat is a timer timeout
// (in_req_type = 0) or a set request (in_req_type = 1, in_switch_value
// bits 9..8 pick seconds, minutes or hours, bits 5..0 give the value).
// Output channel (out_valid/out_ready): one beat per finished second or per
// set request, carrying six digit codes and the LED value. A timeout that
// does not finish a second produces no beat.
// Configuration (cfg_valid/cfg_ready, always ready): cfg_data sets the
// number of timeouts per second; write only while the block is idle.
// An accepted beat is registered in the input register and evaluated there;
// its result, if any, is loaded into the output register when the beat is
// consumed, which waits while a held result is stalled by the receiver.
// Throughput: one beat per cycle while no result waits on the receiver; the
// clock state is updated combinationally between the input and output registers.
// When the receiver stalls, the output register holds its beat; a timeout
// that yields no result still drains, and input stalls only once a result
// is waiting behind the held one.
// Reset clears the clock to 00:00:00, the LED to zero and the per-second
// count to 10; both channels come out of reset empty.
module hms_clock_seven_segment_core
  import hcss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [9:0] in_switch_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_seg_hour_tens,
  output logic [7:0] out_seg_hour_ones,
  output logic [7:0] out_seg_min_tens,
  output logic [7:0] out_seg_min_ones,
  output logic [7:0] out_seg_sec_tens,
  output logic [7:0] out_seg_sec_ones,
  output logic [4:0] out_led_pattern
);

  logic       s1_valid_r;
  logic       s1_req_r;
  logic [9:0] s1_sw_r;
  logic       out_valid_r, out_valid_nxt;
  seg_t       seg_r;
  logic [4:0] led_r;

  logic       emit;
  logic       consume;
  logic       load_out;
  time_t      time_nxt;
  seg_t       seg_nxt;

  assign cfg_ready = 1'b1;
  assign consume   = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign load_out  = consume && emit;
  assign in_ready  = !s1_valid_r || consume;

  hcss_time_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_wdata    (cfg_data),
    .fire         (consume),
    .req_type     (s1_req_r),
    .switch_value (s1_sw_r),
    .emit         (emit),
    .time_nxt     (time_nxt)
  );

  hcss_seg_encode u_enc (
    .tm  (time_nxt),
    .seg (seg_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r <= in_req_type;
      s1_sw_r  <= in_switch_value;
    end
    if (load_out) begin
      seg_r <= seg_nxt;
      led_r <= time_nxt.led;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seg_hour_tens = seg_r.hour_tens;
  assign out_seg_hour_ones = seg_r.hour_ones;
  assign out_seg_min_tens  = seg_r.min_tens;
  assign out_seg_min_ones  = seg_r.min_ones;
  assign out_seg_sec_tens  = seg_r.sec_tens;
  assign out_seg_sec_ones  = seg_r.sec_ones;
  assign out_led_pattern   = led_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !load_out)
    else $error("held result overwritten");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && emit && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result is blocked");

  a_timeout_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !emit |-> consume)
    else $error("silent timeout not drained");

endmodule
